// File: rtl/segint_pkg.sv
// Package: shared widths for the segment intersection block.
package segint_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
endpackage

// File: rtl/segint_if.sv
// Interfaces: valid/ready channels for segment pairs and results.
interface segint_in_if #(parameter int CW = segint_pkg::COORD_BITS);
  logic valid;
  logic ready;
  logic signed [CW-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
  logic signed [CW-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
  modport source(output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                 b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink(input valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segint_out_if #(parameter int OW = segint_pkg::COORD_BITS + segint_pkg::FRAC_BITS);
  logic valid;
  logic ready;
  logic hit;
  logic signed [OW-1:0] point_x, point_y;
  logic parallel;
  logic degenerate;
  modport source(output valid, hit, point_x, point_y, parallel, degenerate, input ready);
  modport sink(input valid, hit, point_x, point_y, parallel, degenerate, output ready);
endinterface

// File: rtl/segment_intersection.sv
// Segment intersection: six front stages, then one stage per quotient bit, then output.
// Throughput: one segment pair per cycle; the whole pipe advances when the output is free.
// A stall holds every stage; no item is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module segment_intersection #(
  parameter int COORD_BITS = segint_pkg::COORD_BITS,
  parameter int FRAC_BITS  = segint_pkg::FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  segint_in_if.sink    in_ch,
  segint_out_if.source out_ch
);
  localparam int CW = COORD_BITS;
  localparam int OW = COORD_BITS + FRAC_BITS;
  localparam int MW = 4 * CW + FRAC_BITS + 1;
  localparam int DW = 2 * CW + 2;
  localparam int SW = 5 + 2 * CW;

  logic en;
  logic f_v, f_hit, f_par, f_deg, f_div, f_nx_neg, f_ny_neg;
  logic [MW-1:0] f_nx, f_ny;
  logic [DW-1:0] f_den;
  logic signed [CW-1:0] f_cx, f_cy;

  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  segint_front #(.CW(CW), .FW(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
    .ax0(in_ch.a_start_x), .ay0(in_ch.a_start_y), .ax1(in_ch.a_end_x), .ay1(in_ch.a_end_y),
    .bx0(in_ch.b_start_x), .by0(in_ch.b_start_y), .bx1(in_ch.b_end_x), .by1(in_ch.b_end_y),
    .out_valid(f_v), .out_hit(f_hit), .out_par(f_par), .out_deg(f_deg), .out_div(f_div),
    .out_negx(f_nx_neg), .out_negy(f_ny_neg), .out_nx(f_nx), .out_ny(f_ny),
    .out_den(f_den), .out_cx(f_cx), .out_cy(f_cy)
  );

  // the point lies within both boxes, so |quotient| fits OW bits
  logic          dx_v, dy_v;
  logic [OW-1:0] qx, qy;
  logic [SW-1:0] side_in, side_x, side_y;
  assign side_in = {f_hit, f_par, f_deg, f_div, f_nx_neg, f_cx, f_cy};

  segint_divpipe #(.NW(MW), .DW(DW), .QW(OW), .SW(SW)) u_divx (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_v), .in_num(f_nx), .in_den(f_den),
    .in_side(side_in), .out_valid(dx_v), .out_quo(qx), .out_side(side_x)
  );

  segint_divpipe #(.NW(MW), .DW(DW), .QW(OW), .SW(SW)) u_divy (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_v), .in_num(f_ny), .in_den(f_den),
    .in_side({4'b0, f_ny_neg, {2*CW{1'b0}}}), .out_valid(dy_v), .out_quo(qy),
    .out_side(side_y)
  );

  logic s_hit, s_par, s_deg, s_div, s_negx, s_negy;
  logic signed [CW-1:0] s_cx, s_cy;
  assign {s_hit, s_par, s_deg, s_div, s_negx, s_cx, s_cy} = side_x;
  assign s_negy = side_y[2*CW];

  logic hit_r, par_r, deg_r;
  logic signed [OW-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dx_v && dy_v;
    if (en) begin
      hit_r <= s_hit;
      par_r <= s_par;
      deg_r <= s_deg;
      if (!s_hit) begin
        px_r <= '0;
        py_r <= '0;
      end else if (s_div) begin
        px_r <= s_negx ? OW'(-qx) : qx;
        py_r <= s_negy ? OW'(-qy) : qy;
      end else begin
        px_r <= OW'({s_cx, {FRAC_BITS{1'b0}}});
        py_r <= OW'({s_cy, {FRAC_BITS{1'b0}}});
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = hit_r;
  assign out_ch.parallel   = par_r;
  assign out_ch.degenerate = deg_r;
  assign out_ch.point_x    = px_r;
  assign out_ch.point_y    = py_r;
endmodule

// File: rtl/segint_divpipe.sv
// Pipelined restoring divider: one quotient bit per stage, with sideband.
module segint_divpipe #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  // remainder stays below den, so DW+1 bits are enough
  logic          v_r   [1:QW];
  logic [NW-1:0] n_r   [1:QW];
  logic [DW-1:0] d_r   [1:QW];
  logic [DW:0]   rem_r [1:QW];
  logic [QW-1:0] q_r   [1:QW];
  logic [SW-1:0] s_r   [1:QW];

  // quotient fits in QW bits, so the numerator bits above QW form the
  // initial remainder, which is below den
  for (genvar i = 0; i < QW; i++) begin : g_st
    logic          v_i;
    logic [NW-1:0] n_i;
    logic [DW-1:0] d_i;
    logic [DW:0]   rem_i;
    logic [QW-1:0] q_i;
    logic [SW-1:0] s_i;
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    if (i == 0) begin : g_first
      assign v_i   = in_valid;
      assign n_i   = in_num;
      assign d_i   = in_den;
      assign rem_i = (DW+1)'(in_num >> QW);
      assign q_i   = '0;
      assign s_i   = in_side;
    end else begin : g_next
      assign v_i   = v_r[i];
      assign n_i   = n_r[i];
      assign d_i   = d_r[i];
      assign rem_i = rem_r[i];
      assign q_i   = q_r[i];
      assign s_i   = s_r[i];
    end
    assign sh = {rem_i, n_i[QW-1-i]};
    assign df = sh - {2'b00, d_i};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_i;
      end
      if (en) begin
        n_r[i+1] <= n_i;
        d_r[i+1] <= d_i;
        s_r[i+1] <= s_i;
        if (!df[DW+1]) begin
          rem_r[i+1] <= df[DW:0];
          q_r[i+1]   <= {q_i[QW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= sh[DW:0];
          q_r[i+1]   <= {q_i[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quo   = q_r[QW];
  assign out_side  = s_r[QW];
endmodule

// File: rtl/segint_front.sv
// Front stages: differences, products, numerators, box tests and fallback.
module segint_front #(
  parameter int CW = segint_pkg::COORD_BITS,
  parameter int FW = segint_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1,
  output logic                out_valid,
  output logic                out_hit,
  output logic                out_par,
  output logic                out_deg,
  output logic                out_div,
  output logic                out_negx,
  output logic                out_negy,
  output logic [4*CW+FW:0]    out_nx,
  output logic [4*CW+FW:0]    out_ny,
  output logic [2*CW+1:0]     out_den,
  output logic signed [CW-1:0] out_cx,
  output logic signed [CW-1:0] out_cy
);
  localparam int DWD = CW + 1;
  localparam int PW  = 2 * CW + 2;
  localparam int NWD = 3 * CW + 4;
  localparam int MW  = 4 * CW + FW + 1;

  // stage 1: differences, products for c1, c2, den
  logic v1_r;
  logic signed [CW-1:0]  ax0_1r, ay0_1r, ax1_1r, ay1_1r, bx0_1r, by0_1r, bx1_1r, by1_1r;
  logic signed [DWD-1:0] dax_1r, day_1r, dbx_1r, dby_1r;
  logic signed [PW-1:0]  p1_1r, p2_1r, p3_1r, p4_1r, p5_1r, p6_1r;
  logic                  deg_1r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
    if (en) begin
      ax0_1r <= ax0; ay0_1r <= ay0; ax1_1r <= ax1; ay1_1r <= ay1;
      bx0_1r <= bx0; by0_1r <= by0; bx1_1r <= bx1; by1_1r <= by1;
      dax_1r <= DWD'(ax0) - DWD'(ax1);
      day_1r <= DWD'(ay0) - DWD'(ay1);
      dbx_1r <= DWD'(bx0) - DWD'(bx1);
      dby_1r <= DWD'(by0) - DWD'(by1);
      p1_1r  <= PW'(ax0) * PW'(ay1);
      p2_1r  <= PW'(ay0) * PW'(ax1);
      p3_1r  <= PW'(bx0) * PW'(by1);
      p4_1r  <= PW'(by0) * PW'(bx1);
      p5_1r  <= PW'(DWD'(ax0) - DWD'(ax1)) * PW'(DWD'(by0) - DWD'(by1));
      p6_1r  <= PW'(DWD'(ay0) - DWD'(ay1)) * PW'(DWD'(bx0) - DWD'(bx1));
      deg_1r <= (ax0 == ax1 && ay0 == ay1) || (bx0 == bx1 && by0 == by1);
    end
  end

  // stage 2: c1, c2, den
  logic v2_r;
  logic signed [CW-1:0]  ax0_2r, ay0_2r, ax1_2r, ay1_2r, bx0_2r, by0_2r, bx1_2r, by1_2r;
  logic signed [DWD-1:0] dax_2r, day_2r, dbx_2r, dby_2r;
  logic signed [PW-1:0]  c1_2r, c2_2r, den_2r;
  logic                  deg_2r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      ax0_2r <= ax0_1r; ay0_2r <= ay0_1r; ax1_2r <= ax1_1r; ay1_2r <= ay1_1r;
      bx0_2r <= bx0_1r; by0_2r <= by0_1r; bx1_2r <= bx1_1r; by1_2r <= by1_1r;
      dax_2r <= dax_1r; day_2r <= day_1r; dbx_2r <= dbx_1r; dby_2r <= dby_1r;
      c1_2r  <= p1_1r - p2_1r;
      c2_2r  <= p3_1r - p4_1r;
      den_2r <= p5_1r - p6_1r;
      deg_2r <= deg_1r;
    end
  end

  // stage 3: numerator products
  logic v3_r;
  logic signed [CW-1:0]  ax0_3r, ay0_3r, ax1_3r, ay1_3r, bx0_3r, by0_3r, bx1_3r, by1_3r;
  logic signed [NWD-1:0] q1_3r, q2_3r, q3_3r, q4_3r;
  logic signed [PW-1:0]  den_3r;
  logic                  deg_3r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      ax0_3r <= ax0_2r; ay0_3r <= ay0_2r; ax1_3r <= ax1_2r; ay1_3r <= ay1_2r;
      bx0_3r <= bx0_2r; by0_3r <= by0_2r; bx1_3r <= bx1_2r; by1_3r <= by1_2r;
      q1_3r  <= NWD'(c1_2r) * NWD'(dbx_2r);
      q2_3r  <= NWD'(c2_2r) * NWD'(dax_2r);
      q3_3r  <= NWD'(c1_2r) * NWD'(dby_2r);
      q4_3r  <= NWD'(c2_2r) * NWD'(day_2r);
      den_3r <= den_2r;
      deg_3r <= deg_2r;
    end
  end

  // stage 4: signed numerators normalised to positive den, min/max per box
  logic v4_r;
  logic signed [NWD-1:0] nx_4r, ny_4r;
  logic signed [PW-1:0]  den_4r;
  logic signed [CW-1:0]  axl_4r, axh_4r, ayl_4r, ayh_4r, bxl_4r, bxh_4r, byl_4r, byh_4r;
  logic signed [CW-1:0]  cx_4r, cy_4r;
  logic                  deg_4r, par_4r, fb_4r;
  logic signed [NWD-1:0] nx_s, ny_s;
  logic signed [CW-1:0]  axl, axh, ayl, ayh, bxl, bxh, byl, byh, cx, cy;
  logic                  a0b, a1b, b0a;

  always_comb begin
    nx_s = q1_3r - q2_3r;
    ny_s = q3_3r - q4_3r;
    if (den_3r < 0) begin
      nx_s = -nx_s;
      ny_s = -ny_s;
    end
    axl = (ax0_3r < ax1_3r) ? ax0_3r : ax1_3r; axh = (ax0_3r < ax1_3r) ? ax1_3r : ax0_3r;
    ayl = (ay0_3r < ay1_3r) ? ay0_3r : ay1_3r; ayh = (ay0_3r < ay1_3r) ? ay1_3r : ay0_3r;
    bxl = (bx0_3r < bx1_3r) ? bx0_3r : bx1_3r; bxh = (bx0_3r < bx1_3r) ? bx1_3r : bx0_3r;
    byl = (by0_3r < by1_3r) ? by0_3r : by1_3r; byh = (by0_3r < by1_3r) ? by1_3r : by0_3r;
    a0b = ax0_3r >= bxl && ax0_3r <= bxh && ay0_3r >= byl && ay0_3r <= byh;
    a1b = ax1_3r >= bxl && ax1_3r <= bxh && ay1_3r >= byl && ay1_3r <= byh;
    b0a = bx0_3r >= axl && bx0_3r <= axh && by0_3r >= ayl && by0_3r <= ayh;
    if (a0b) begin
      cx = ax0_3r; cy = ay0_3r;
    end else if (a1b) begin
      cx = ax1_3r; cy = ay1_3r;
    end else if (b0a) begin
      cx = bx0_3r; cy = by0_3r;
    end else begin
      cx = bx1_3r; cy = by1_3r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      nx_4r  <= nx_s;
      ny_4r  <= ny_s;
      den_4r <= (den_3r < 0) ? -den_3r : den_3r;
      axl_4r <= axl; axh_4r <= axh; ayl_4r <= ayl; ayh_4r <= ayh;
      bxl_4r <= bxl; bxh_4r <= bxh; byl_4r <= byl; byh_4r <= byh;
      cx_4r  <= cx;  cy_4r  <= cy;
      deg_4r <= deg_3r;
      par_4r <= den_3r == 0;
      fb_4r  <= cx >= axl && cx <= axh && cy >= ayl && cy <= ayh &&
                cx >= bxl && cx <= bxh && cy >= byl && cy <= byh;
    end
  end

  // stage 5: limit * den products
  logic v5_r;
  logic signed [NWD-1:0] nx_5r, ny_5r;
  logic signed [PW-1:0]  den_5r;
  logic signed [NWD-1:0] l0_5r, l1_5r, l2_5r, l3_5r, l4_5r, l5_5r, l6_5r, l7_5r;
  logic signed [CW-1:0]  cx_5r, cy_5r;
  logic                  deg_5r, par_5r, fb_5r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      nx_5r <= nx_4r; ny_5r <= ny_4r; den_5r <= den_4r;
      l0_5r <= NWD'(axl_4r) * NWD'(den_4r); l1_5r <= NWD'(axh_4r) * NWD'(den_4r);
      l2_5r <= NWD'(ayl_4r) * NWD'(den_4r); l3_5r <= NWD'(ayh_4r) * NWD'(den_4r);
      l4_5r <= NWD'(bxl_4r) * NWD'(den_4r); l5_5r <= NWD'(bxh_4r) * NWD'(den_4r);
      l6_5r <= NWD'(byl_4r) * NWD'(den_4r); l7_5r <= NWD'(byh_4r) * NWD'(den_4r);
      cx_5r <= cx_4r; cy_5r <= cy_4r;
      deg_5r <= deg_4r; par_5r <= par_4r; fb_5r <= fb_4r;
    end
  end

  // stage 6: exact compares, select path
  logic inbox;
  assign inbox = l0_5r <= nx_5r && nx_5r <= l1_5r && l2_5r <= ny_5r && ny_5r <= l3_5r &&
                 l4_5r <= nx_5r && nx_5r <= l5_5r && l6_5r <= ny_5r && ny_5r <= l7_5r;

  logic                  v6_r, hit_6r, par_6r, deg_6r, div_6r, negx_6r, negy_6r;
  logic [MW-1:0]         nx_6r, ny_6r;
  logic [PW-1:0]         den_6r;
  logic signed [CW-1:0]  cx_6r, cy_6r;
  logic [NWD-1:0]        mx, my;

  assign mx = nx_5r[NWD-1] ? NWD'(-nx_5r) : NWD'(nx_5r);
  assign my = ny_5r[NWD-1] ? NWD'(-ny_5r) : NWD'(ny_5r);

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      div_6r  <= !deg_5r && !par_5r && inbox;
      hit_6r  <= !deg_5r && (par_5r ? fb_5r : inbox);
      par_6r  <= par_5r;
      deg_6r  <= deg_5r;
      negx_6r <= nx_5r[NWD-1];
      negy_6r <= ny_5r[NWD-1];
      nx_6r   <= MW'({mx, {FW{1'b0}}});
      ny_6r   <= MW'({my, {FW{1'b0}}});
      den_6r  <= den_5r;
      cx_6r   <= cx_5r;
      cy_6r   <= cy_5r;
    end
  end

  assign out_valid = v6_r;
  assign out_hit   = hit_6r;
  assign out_par   = par_6r;
  assign out_deg   = deg_6r;
  assign out_div   = div_6r;
  assign out_negx  = negx_6r;
  assign out_negy  = negy_6r;
  assign out_nx    = nx_6r;
  assign out_ny    = ny_6r;
  assign out_den   = den_6r;
  assign out_cx    = cx_6r;
  assign out_cy    = cy_6r;
endmodule
